// ----- hw/rtl/sorted_time_key_list_unit_assert.svh -----
// Assertion macros for the sorted time key list unit.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef SORTED_TIME_KEY_LIST_UNIT_ASSERT_SVH
`define SORTED_TIME_KEY_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define STKL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STKL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/stkl_pkg.sv -----
// Shared types, codes and helpers for the sorted time key list unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stkl_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int KEY_W  = HOUR_W + MIN_W;

	localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
	localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LIST   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_REMOVED   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_ENTRY     = 3'd5;
	localparam logic [2:0] ST_BAD_TIME  = 3'd6;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
	} key_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	// broadcast to every cell
	typedef struct packed {
		op_t  op;
		key_t nkey;
	} cell_ctrl_t;

	function automatic logic [KEY_W-1:0] key_val(input key_t k);
		key_val = {k.hour, k.minute};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_time_key_list_unit.sv -----
// Sorted hour:minute key list built as a shifting chain of slot cells.
// Depends on stkl_pkg, stkl_cell and sorted_time_key_list_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to CAPACITY hour:minute keys in ascending order in a row of slot cells.
// Insert, remove, bad time and empty-list items each give one result beat: every cell
// compares its key with the new key in parallel and shifts left or right in one
// step. A list request is accepted first and then gives one beat per entry while
// the output is free, as the chain rotates one slot per beat with cell 0 feeding
// the output register. No new item is taken during a listing.
// Unused kind code 3 is accepted and produces no beat. No clearing pass after reset.
module sorted_time_key_list_unit
	import stkl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	input  wire logic [HOUR_W-1:0] hour,
	input  wire logic [MIN_W-1:0]  minute,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [HOUR_W-1:0]      out_hour,
	output logic [MIN_W-1:0]       out_minute,
	output logic                   last
);

	`include "sorted_time_key_list_unit_assert.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	key_t             out_key_q;
	logic             last_q;

	cell_ctrl_t ctrl;
	key_t       cell_key [CAPACITY];
	logic       cell_s   [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	key_t in_key;
	logic good;
	logic full;
	logic found;
	logic out_free;
	logic in_fire;
	logic list_step;
	logic list_last;
	logic do_insert;
	logic do_remove;
	logic load;
	logic [2:0] load_status;
	key_t       load_key;
	logic       load_last;

	assign in_key   = '{hour: hour, minute: minute};
	assign good     = (hour <= HOUR_MAX) && (minute <= MIN_MAX);
	assign full     = cnt_q == CNT_FULL;
	assign found    = |cell_match;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign list_step = (state_q == S_LIST) && out_free;
	assign list_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	assign do_insert = in_fire && (kind == KIND_INSERT) && good && !full;
	assign do_remove = in_fire && (kind == KIND_REMOVE) && good && found;

	always_comb begin
		ctrl.nkey = in_key;
		if (do_insert)      ctrl.op = OP_INSERT;
		else if (do_remove) ctrl.op = OP_REMOVE;
		else if (list_step) ctrl.op = OP_ROTATE;
		else                ctrl.op = OP_HOLD;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		key_t left_key;
		logic left_s;
		key_t right_key;

		if (i == 0) begin : g_first
			assign left_key = in_key;
			assign left_s   = 1'b0;
		end else begin : g_mid
			assign left_key = cell_key[i-1];
			assign left_s   = cell_s[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_key = cell_key[i];
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		stkl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cnt       (cnt_q),
			.ctrl      (ctrl),
			.left_key  (left_key),
			.left_s    (left_s),
			.right_key (right_key),
			.head_key  (cell_key[0]),
			.key       (cell_key[i]),
			.s         (cell_s[i]),
			.match     (cell_match[i])
		);
	end

	// result beat selection
	always_comb begin
		load        = 1'b0;
		load_status = ST_ENTRY;
		load_key    = in_key;
		load_last   = 1'b1;
		if (list_step) begin
			load      = 1'b1;
			load_key  = cell_key[0];
			load_last = list_last;
		end else if (in_fire) begin
			case (kind)
				KIND_INSERT: begin
					load        = 1'b1;
					load_status = full ? ST_FULL : ST_INSERTED;
				end
				KIND_REMOVE: begin
					load        = 1'b1;
					load_status = found ? ST_REMOVED : ST_NOT_FOUND;
				end
				KIND_LIST: begin
					load        = cnt_q == '0;
					load_status = ST_EMPTY;
					load_key    = '0;
				end
				default: load = 1'b0;
			endcase
			if (!good && (kind == KIND_INSERT || kind == KIND_REMOVE)) begin
				load_status = ST_BAD_TIME;
				load_key    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (do_insert)      cnt_q <= cnt_q + CNT_W'(1);
			else if (do_remove) cnt_q <= cnt_q - CNT_W'(1);

			case (state_q)
				S_IDLE: begin
					if (in_fire && kind == KIND_LIST && cnt_q != '0) begin
						state_q <= S_LIST;
						idx_q   <= '0;
					end
				end
				S_LIST: begin
					if (list_step) begin
						idx_q <= idx_q + IDX_W'(1);
						if (list_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= load_status;
			out_key_q <= load_key;
			last_q    <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_hour   = out_key_q.hour;
	assign out_minute = out_key_q.minute;
	assign last       = last_q;

	`STKL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL, "entry count above capacity")
	`STKL_ASSERT_NOW(a_list_blocks, state_q == S_LIST, !in_ready, "input taken during listing")
	`STKL_ASSERT_NEXT(a_insert_grows, do_insert, cnt_q == $past(cnt_q) + CNT_W'(1), "insert lost")
	`STKL_ASSERT_NEXT(a_list_ends, list_step && list_last, state_q == S_IDLE, "listing overran")

endmodule

`default_nettype wire

// ----- hw/rtl/stkl_cell.sv -----
// One slot of the sorted key chain: holds a key and moves it to or from its neighbors.
// Depends on stkl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stkl_cell
	import stkl_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  wire logic             clk,
	input  wire logic [CNT_W-1:0] cnt,
	input  wire cell_ctrl_t       ctrl,
	input  wire key_t             left_key,
	input  wire logic             left_s,
	input  wire key_t             right_key,
	input  wire key_t             head_key,
	output key_t                  key,
	output logic                  s,
	output logic                  match
);

	localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

	key_t key_q;
	key_t key_d;
	logic occ;
	logic is_end;
	logic is_tail;
	logic gt;
	logic ge;

	assign occ     = POS < cnt;
	assign is_end  = POS == cnt;
	assign is_tail = POS_NEXT == cnt;
	assign gt      = occ && (key_val(key_q) > key_val(ctrl.nkey));
	assign ge      = occ && (key_val(key_q) >= key_val(ctrl.nkey));
	// s: this slot moves right (or is the first free slot) on an insert
	assign s       = gt || is_end;
	assign match   = occ && (key_val(key_q) == key_val(ctrl.nkey));

	always_comb begin
		key_d = key_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (s) key_d = left_s ? left_key : ctrl.nkey;
			end
			OP_REMOVE: begin
				// list is sorted, so the first match is the first slot with key >= new
				if (ge) key_d = right_key;
			end
			OP_ROTATE: begin
				if (occ) key_d = is_tail ? head_key : right_key;
			end
			default: key_d = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	assign key = key_q;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for sorted_time_key_list_unit: directed and random insert, remove and list traffic.
// Depends on stkl_pkg and the RTL of the unit; it checks every result beat against its own list.
`timescale 1ns / 1ps

module tb;
	import stkl_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [2:0]        status;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              last;
	} beat_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        kind;
	logic [HOUR_W-1:0] hour;
	logic [MIN_W-1:0]  minute;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        status;
	logic [HOUR_W-1:0] out_hour;
	logic [MIN_W-1:0]  out_minute;
	logic              last;

	// our copy of the list contents
	key_t  stored_keys [CAPACITY_DEF];
	int    stored_count;
	beat_t pending_beats [$];

	int mismatches;
	int idle_cycles;
	bit calm;
	int hold_off_req;

	sorted_time_key_list_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.hour       (hour),
		.minute     (minute),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_hour   (out_hour),
		.out_minute (out_minute),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_beat(input logic [2:0] st, input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m, input logic lst);
		beat_t b;
		b.status = st;
		b.hour   = h;
		b.minute = m;
		b.last   = lst;
		pending_beats.push_back(b);
	endfunction

	// apply one accepted item to the list copy and queue the beats it must produce
	function automatic void predict_list_op(input logic [1:0] k, input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m);
		key_t nk;
		int   pos;
		int   idx;
		nk.hour   = h;
		nk.minute = m;
		if (k == KIND_LIST) begin
			if (stored_count == 0)
				queue_beat(ST_EMPTY, '0, '0, 1'b1);
			for (idx = 0; idx < stored_count; idx++)
				queue_beat(ST_ENTRY, stored_keys[idx].hour, stored_keys[idx].minute,
					idx == stored_count - 1);
		end else if (k == KIND_INSERT || k == KIND_REMOVE) begin
			if (h > HOUR_MAX || m > MIN_MAX) begin
				queue_beat(ST_BAD_TIME, '0, '0, 1'b1);
			end else if (k == KIND_INSERT) begin
				if (stored_count >= CAPACITY_DEF) begin
					queue_beat(ST_FULL, h, m, 1'b1);
				end else begin
					pos = 0;
					// key compares hour first, then minute; equal keys go after
					while (pos < stored_count && key_val(stored_keys[pos]) <= key_val(nk))
						pos++;
					for (idx = stored_count; idx > pos; idx--)
						stored_keys[idx] = stored_keys[idx - 1];
					stored_keys[pos] = nk;
					stored_count++;
					queue_beat(ST_INSERTED, h, m, 1'b1);
				end
			end else begin
				pos = 0;
				while (pos < stored_count && stored_keys[pos] != nk)
					pos++;
				if (pos == stored_count) begin
					queue_beat(ST_NOT_FOUND, h, m, 1'b1);
				end else begin
					for (idx = pos; idx + 1 < stored_count; idx++)
						stored_keys[idx] = stored_keys[idx + 1];
					stored_count--;
					queue_beat(ST_REMOVED, h, m, 1'b1);
				end
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		beat_t b;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$error("beat with no pending result: status %0d %0d:%0d", status, out_hour,
					out_minute);
				mismatches++;
			end else begin
				b = pending_beats.pop_front();
				check_field("status", 32'(b.status), 32'(status));
				check_field("out_hour", 32'(b.hour), 32'(out_hour));
				check_field("out_minute", 32'(b.minute), 32'(out_minute));
				check_field("last", 32'(b.last), 32'(last));
			end
		end
	end

	// receiver: random ready, with an occasional long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req > 0) begin
				n = hold_off_req;
				hold_off_req = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == STALL_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// entered and left at a rising edge
	task automatic send_item(input logic [1:0] k, input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m);
		in_valid <= 1'b1;
		kind     <= k;
		hour     <= h;
		minute   <= m;
		do @(posedge clk); while (!in_ready);
		predict_list_op(k, h, m);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_item(input int insert_pct);
		int          r;
		key_t        nk;
		logic [1:0]  k;
		r = $urandom_range(99);
		nk.hour   = HOUR_W'($urandom_range(23));
		nk.minute = MIN_W'($urandom_range(59));
		if (r < 8) begin
			// noise: full field range, often a bad time or the unused code
			r = $urandom_range(2);
			k = (r == 0) ? KIND_INSERT : (r == 1) ? KIND_REMOVE : KIND_UNUSED;
			send_item(k, HOUR_W'($urandom_range(31)), MIN_W'($urandom_range(63)));
		end else if (r < 20) begin
			send_item(KIND_LIST, HOUR_W'($urandom_range(31)), MIN_W'($urandom_range(63)));
		end else begin
			// reuse a stored key often so duplicates and remove hits are common
			if (stored_count > 0 && $urandom_range(99) < 60)
				nk = stored_keys[$urandom_range(stored_count - 1)];
			k = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			send_item(k, nk.hour, nk.minute);
		end
	endtask

	task automatic test_empty_list();
		send_item(KIND_LIST, 5'd31, 6'd63);
		send_item(KIND_REMOVE, 5'd5, 6'd5);
		wait_for_results();
	endtask

	task automatic test_insert_order();
		send_item(KIND_INSERT, 5'd23, 6'd59);
		send_item(KIND_INSERT, 5'd0, 6'd0);
		send_item(KIND_INSERT, 5'd12, 6'd30);
		send_item(KIND_INSERT, 5'd12, 6'd30);
		send_item(KIND_INSERT, 5'd12, 6'd29);
		send_item(KIND_LIST, 5'd0, 6'd0);
		wait_for_results();
	endtask

	task automatic test_bad_time();
		send_item(KIND_INSERT, 5'd24, 6'd0);
		send_item(KIND_INSERT, 5'd31, 6'd0);
		send_item(KIND_INSERT, 5'd0, 6'd60);
		send_item(KIND_INSERT, 5'd0, 6'd63);
		send_item(KIND_REMOVE, 5'd24, 6'd10);
		send_item(KIND_REMOVE, 5'd10, 6'd60);
		send_item(KIND_UNUSED, 5'd12, 6'd30);
		send_item(KIND_LIST, 5'd24, 6'd60);
		wait_for_results();
	endtask

	task automatic test_remove();
		send_item(KIND_REMOVE, 5'd12, 6'd30);
		send_item(KIND_REMOVE, 5'd7, 6'd7);
		send_item(KIND_REMOVE, 5'd0, 6'd0);
		send_item(KIND_REMOVE, 5'd23, 6'd59);
		send_item(KIND_LIST, 5'd0, 6'd0);
		wait_for_results();
	endtask

	// no idling on either side here
	task automatic test_full_list();
		key_t nk;
		calm = 1'b1;
		while (stored_count < CAPACITY_DEF)
			send_item(KIND_INSERT, HOUR_W'($urandom_range(23)), MIN_W'($urandom_range(59)));
		repeat (3) send_item(KIND_INSERT, HOUR_W'($urandom_range(23)),
			MIN_W'($urandom_range(59)));
		send_item(KIND_LIST, 5'd0, 6'd0);
		while (stored_count > 0) begin
			nk = stored_keys[$urandom_range(stored_count - 1)];
			send_item(KIND_REMOVE, nk.hour, nk.minute);
		end
		send_item(KIND_LIST, 5'd0, 6'd0);
		wait_for_results();
		calm = 1'b0;
	endtask

	// receiver stalls long while items keep coming, so the input backs up
	task automatic test_output_stall();
		hold_off_req = 300;
		repeat (40) send_random_item(60);
		wait_for_results();
	endtask

	task automatic test_random_mix(input int count, input int insert_pct);
		repeat (count) send_random_item(insert_pct);
		wait_for_results();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_INSERT;
		hour         = '0;
		minute       = '0;
		stored_count = 0;
		mismatches   = 0;
		idle_cycles  = 0;
		calm         = 1'b0;
		hold_off_req = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_insert_order();
		test_bad_time();
		test_remove();
		test_full_list();
		test_random_mix(120, 65);
		test_output_stall();
		test_random_mix(100, 25);
		test_random_mix(80, 45);

		wait_for_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/stkl_pkg.sv
hw/rtl/stkl_cell.sv
hw/rtl/sorted_time_key_list_unit.sv
sim/tb.sv
